>>> src/pan_coordinator_frame_responder_top_macros.svh
// Assertion macros for the PAN coordinator frame responder.
// Used by the checker module; depends on nothing else.
`ifndef PAN_COORDINATOR_FRAME_RESPONDER_TOP_MACROS_SVH
`define PAN_COORDINATOR_FRAME_RESPONDER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PCFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcfr assertion failed");

// Next-cycle implication, disabled while in reset.
`define PCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcfr assertion failed");

`endif

>>> src/pcfr_pkg.sv
// Shared types and constants of the PAN coordinator frame responder.
// No dependencies; used by the decoder, the top level and the checker.
`timescale 1ns / 1ps

package pcfr_pkg;

    // Received frame request
    typedef struct packed {
        logic [63:0] src_address;
        logic [6:0]  payload_len;
        logic [7:0]  byte_first;
        logic [7:0]  byte_second;
        logic [7:0]  byte_third;
    } in_item_t;

    // Reply description request
    typedef struct packed {
        logic        send_reply;
        logic [1:0]  dest_addr_mode;
        logic [2:0]  reply_frame_type;
        logic        pan_compress;
        logic        ack_request;
        logic [2:0]  reply_len;
        logic [55:0] reply_bytes;
        logic        forward_up;
    } out_item_t;

    // Per-device and global state changes caused by one frame
    typedef struct packed {
        logic       online_we;
        logic       online_val;
        logic       seq_load;
        logic [7:0] seq_val;
        logic       seq_incr;
        logic       tx_incr;
    } upd_t;

    // Configuration register indexes
    localparam logic REG_DEVICE_ADDRESS_A = 1'b0;
    localparam logic REG_DEVICE_ADDRESS_B = 1'b1;

    // Message kind codes (payload byte 0)
    localparam logic [7:0] KIND_BEACON     = 8'h07;
    localparam logic [7:0] KIND_ASSOC_DATA = 8'h01;
    localparam logic [7:0] KIND_START      = 8'h13;
    localparam logic [7:0] KIND_ONLINE     = 8'h08;
    localparam logic [7:0] KIND_FINAL_ACK  = 8'h02;
    localparam logic [7:0] KIND_RESYNC     = 8'h0A;

    // Device type codes seen in a beacon
    localparam logic [7:0] DEVTYPE_ONE = 8'h0f;
    localparam logic [7:0] DEVTYPE_TWO = 8'h2f;

    // Reply byte constants
    localparam logic [7:0] RB_BEACON_HDR  = 8'hff;
    localparam logic [7:0] RB_BEACON_ID   = 8'h45;
    localparam logic [7:0] RB_BEACON_MARK = 8'h7e;
    localparam logic [7:0] RB_ASSOC_CMD   = 8'h02;
    localparam logic [7:0] RB_ASSOC_FE    = 8'hfe;
    localparam logic [7:0] RB_ASSOC_FF    = 8'hff;
    localparam logic [7:0] RB_START_ACK   = 8'h14;
    localparam logic [7:0] RB_MORE        = 8'h09;
    localparam logic [7:0] RB_DONE        = 8'h0A;
    localparam logic [7:0] RB_DATA_DONE   = 8'h02;
    localparam logic [7:0] MORE_FLAG      = 8'h01;

    // Frame control codes
    localparam logic [1:0] DAM_NONE     = 2'd0;
    localparam logic [1:0] DAM_LONG     = 2'd3;
    localparam logic [2:0] FT_BEACON    = 3'd0;
    localparam logic [2:0] FT_DATA      = 3'd1;
    localparam logic [2:0] FT_COMMAND   = 3'd3;

endpackage

>>> src/pcfr_decode.sv
// Per-frame case selection and reply construction.
// Depends on pcfr_pkg; purely combinational.
`timescale 1ns / 1ps

module pcfr_decode (
    input  pcfr_pkg::in_item_t  item,
    input  logic                online,
    input  logic [7:0]          seq,
    input  logic [7:0]          tx,
    output pcfr_pkg::out_item_t result,
    output pcfr_pkg::upd_t      upd
);
    import pcfr_pkg::*;

    logic       len_nz;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] beacon_b5;
    logic [7:0] kind_k;

    // Payload bytes beyond the length read as zero
    assign len_nz    = (item.payload_len != 7'd0);
    assign b0        = len_nz ? item.byte_first : 8'h00;
    assign b1        = (item.payload_len > 7'd1) ? item.byte_second : 8'h00;
    assign b2        = (item.payload_len > 7'd2) ? item.byte_third : 8'h00;
    assign beacon_b5 = (b1 == DEVTYPE_ONE) ? 8'h01 : 8'h02;
    assign kind_k    = (b2 == MORE_FLAG) ? RB_MORE : RB_DONE;

    always_comb
    begin
        result     = '0;
        upd        = '0;
        upd.seq_val = b1;
        if (!len_nz)
        begin
            result.forward_up = 1'b1;
        end
        else if (b0 == KIND_BEACON)
        begin
            upd.online_we      = 1'b1;
            upd.online_val     = 1'b0;
            result.send_reply  = 1'b1;
            result.dest_addr_mode   = DAM_NONE;
            result.reply_frame_type = FT_BEACON;
            result.reply_len   = 3'd7;
            result.reply_bytes = {8'h00, beacon_b5, RB_BEACON_MARK, 8'h00, 8'h00,
                                  RB_BEACON_ID, RB_BEACON_HDR};
        end
        else if (!online && b0 == KIND_ASSOC_DATA)
        begin
            upd.online_we      = 1'b1;
            upd.online_val     = 1'b0;
            result.send_reply  = 1'b1;
            result.dest_addr_mode   = DAM_LONG;
            result.reply_frame_type = FT_COMMAND;
            result.pan_compress = 1'b1;
            result.ack_request  = 1'b1;
            result.reply_len    = 3'd4;
            result.reply_bytes  = {24'h0, 8'h00, RB_ASSOC_FF, RB_ASSOC_FE, RB_ASSOC_CMD};
        end
        else if (b0 == KIND_START)
        begin
            upd.online_we      = 1'b1;
            upd.online_val     = 1'b1;
            upd.seq_load       = 1'b1;
            upd.tx_incr        = 1'b1;
            result.send_reply  = 1'b1;
            result.dest_addr_mode   = DAM_LONG;
            result.reply_frame_type = FT_DATA;
            result.pan_compress = 1'b1;
            result.ack_request  = 1'b1;
            result.reply_len    = 3'd4;
            result.reply_bytes  = {24'h0, 8'h00, b1, tx, RB_START_ACK};
        end
        else if (b0 == KIND_ONLINE)
        begin
            upd.online_we      = 1'b1;
            upd.online_val     = 1'b1;
            upd.seq_incr       = 1'b1;
            upd.tx_incr        = 1'b1;
            result.send_reply  = 1'b1;
            result.dest_addr_mode   = DAM_LONG;
            result.reply_frame_type = FT_DATA;
            result.pan_compress = 1'b1;
            result.reply_len    = 3'd3;
            result.reply_bytes  = {32'h0, seq, tx, kind_k};
        end
        else if (online && b0 == KIND_ASSOC_DATA)
        begin
            upd.online_we      = 1'b1;
            upd.online_val     = 1'b1;
            upd.seq_load       = 1'b1;
            upd.tx_incr        = 1'b1;
            result.send_reply  = 1'b1;
            result.dest_addr_mode   = DAM_LONG;
            result.reply_frame_type = FT_DATA;
            result.pan_compress = 1'b1;
            result.reply_len    = 3'd4;
            result.forward_up   = 1'b1;
            result.reply_bytes  = {24'h0, 8'h00, b1, tx,
                                   ((b2 == MORE_FLAG) ? RB_MORE : RB_DATA_DONE)};
        end
        else if (b0 == KIND_FINAL_ACK)
        begin
            upd.online_we      = 1'b1;
            upd.online_val     = 1'b1;
            upd.seq_incr       = 1'b1;
            upd.tx_incr        = 1'b1;
            result.send_reply  = 1'b1;
            result.dest_addr_mode   = DAM_LONG;
            result.reply_frame_type = FT_DATA;
            result.pan_compress = 1'b1;
            result.reply_len    = 3'd4;
            result.forward_up   = 1'b1;
            result.reply_bytes  = {24'h0, 8'h00, seq, tx, kind_k};
        end
        else if (b0 == KIND_RESYNC)
        begin
            upd.seq_load = 1'b1;
        end
        else
        begin
            result.forward_up = 1'b1;
        end
    end

endmodule

>>> src/pan_coordinator_frame_responder_top.sv
// Top level of the PAN coordinator frame responder: frame register, device
// state, reply register. Depends on pcfr_pkg and pcfr_decode.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   frame    | frame_valid / frame_stall | frame (pcfr_pkg::in_item_t)
//   reply    | reply_valid / reply_stall | reply (pcfr_pkg::out_item_t)
//   config   | cfg_we                    | cfg_index, cfg_data
//
// One frame per cycle sustained while the reply side is not stalled; a reply
// passes the frame register, then the reply register. Device state updates as the frame
// leaves the frame register, so back-to-back frames see each other's effects.
// Reset clears addresses, online flags, sequences and both valid bits.
// A stalled reply holds; the frame register keeps taking requests until it
// is also full.
`timescale 1ns / 1ps

module pan_coordinator_frame_responder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_valid,
    output logic                frame_stall,
    input  pcfr_pkg::in_item_t  frame,
    output logic                reply_valid,
    input  logic                reply_stall,
    output pcfr_pkg::out_item_t reply,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data
);
    import pcfr_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    in_item_t    s1_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;
    logic [63:0] addr_a_reg;
    logic [63:0] addr_b_reg;
    logic [1:0]  online_reg;
    logic [7:0]  seq_a_reg;
    logic [7:0]  seq_b_reg;
    logic [7:0]  tx_reg;

    logic        s1_adv;
    logic        frame_acc;
    logic        match_a;
    logic        match_b;
    logic        online_rd;
    logic [7:0]  seq_rd;
    out_item_t   result;
    upd_t        upd;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !reply_stall);
    assign frame_stall = s1_valid_reg && !s1_adv;
    assign frame_acc = frame_valid && !frame_stall;

    assign s1_valid_next  = frame_acc || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && reply_stall);

    assign match_a = (s1_item_reg.src_address == addr_a_reg);
    assign match_b = (s1_item_reg.src_address == addr_b_reg);

    // Device B wins a read when both addresses match
    assign online_rd = match_b ? online_reg[1] : (match_a ? online_reg[0] : 1'b0);
    assign seq_rd    = match_b ? seq_b_reg : (match_a ? seq_a_reg : 8'h00);

    pcfr_decode u_decode (
        .item   (s1_item_reg),
        .online (online_rd),
        .seq    (seq_rd),
        .tx     (tx_reg),
        .result (result),
        .upd    (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_acc)
        begin
            s1_item_reg <= frame;
        end
        if (s1_adv)
        begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_a_reg <= 64'h0;
            addr_b_reg <= 64'h0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DEVICE_ADDRESS_A)
            begin
                addr_a_reg <= cfg_data;
            end
            if (cfg_index == REG_DEVICE_ADDRESS_B)
            begin
                addr_b_reg <= cfg_data;
            end
        end
    end

    // Apply state changes to every matching device, and to the shared tx counter, as the frame advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg <= 2'b00;
            seq_a_reg  <= 8'h00;
            seq_b_reg  <= 8'h00;
            tx_reg     <= 8'h00;
        end
        else if (s1_adv)
        begin
            if (upd.tx_incr)
            begin
                tx_reg <= tx_reg + 8'd1;
            end
            if (match_a)
            begin
                if (upd.online_we)
                begin
                    online_reg[0] <= upd.online_val;
                end
                if (upd.seq_load)
                begin
                    seq_a_reg <= upd.seq_val;
                end
                else if (upd.seq_incr)
                begin
                    seq_a_reg <= seq_a_reg + 8'd1;
                end
            end
            if (match_b)
            begin
                if (upd.online_we)
                begin
                    online_reg[1] <= upd.online_val;
                end
                if (upd.seq_load)
                begin
                    seq_b_reg <= upd.seq_val;
                end
                else if (upd.seq_incr)
                begin
                    seq_b_reg <= seq_b_reg + 8'd1;
                end
            end
        end
    end

    assign reply_valid = out_valid_reg;
    assign reply       = out_item_reg;

endmodule

>>> src/pcfr_checker.sv
// Port-level checks for the PAN coordinator frame responder, bound to the top.
// Depends on pcfr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pan_coordinator_frame_responder_top_macros.svh"

module pcfr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                frame_valid,
    input logic                frame_stall,
    input logic                reply_valid,
    input logic                reply_stall,
    input pcfr_pkg::out_item_t reply
);
    import pcfr_pkg::*;

    // A held reply keeps its contents
    `PCFR_ASSERT_NEXT(a_reply_hold, clk, rst_n, reply_valid && reply_stall,
                      reply_valid && $stable(reply))

    // A reply only appears after a frame request was taken and passed the frame register, then the reply register
    `PCFR_ASSERT_NOW(a_reply_latency, clk, rst_n, $rose(reply_valid),
                     $past(frame_valid && !frame_stall, 2))

    // No frame to send means an empty reply body
    `PCFR_ASSERT_NOW(a_no_send_empty, clk, rst_n, reply_valid && !reply.send_reply,
                     reply.reply_len == 3'd0 && reply.reply_bytes == 56'h0 &&
                     reply.dest_addr_mode == DAM_NONE)

    // A sent reply carries three, four or seven bytes
    `PCFR_ASSERT_NOW(a_send_len, clk, rst_n, reply_valid && reply.send_reply,
                     reply.reply_len == 3'd3 || reply.reply_len == 3'd4 ||
                     reply.reply_len == 3'd7)

endmodule

bind pan_coordinator_frame_responder_top pcfr_checker u_pcfr_checker (.*);

>>> sim/pan_coordinator_frame_responder_top_tb.sv
// Self-checking testbench for pan_coordinator_frame_responder_top: drives frames,
// predicts each reply with an in-bench model of the device state and compares.
// Depends on pcfr_pkg and the RTL under src.
`timescale 1ns / 1ps

module pan_coordinator_frame_responder_top_tb;
    import pcfr_pkg::*;

    localparam int          STALL_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES = 6;
    localparam logic [7:0]  BEACON_SLOT_ONE = 8'h01;
    localparam logic [7:0]  BEACON_SLOT_TWO = 8'h02;
    localparam logic [7:0]  KIND_UNKNOWN    = 8'hFF;
    localparam logic [63:0] ADDR_ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        frame_valid = 1'b0;
    logic        frame_stall;
    in_item_t    frame = '0;
    logic        reply_valid;
    logic        reply_stall = 1'b0;
    out_item_t   reply;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_data = '0;

    // Shadow of the block's registers and per-device state
    logic [63:0] dev_addr [2];
    logic        dev_online [2];
    logic [7:0]  dev_seq [2];
    logic [7:0]  tx_seq;

    out_item_t   expected_replies [$];
    int unsigned mismatches = 0;
    int unsigned failures = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned idle_pct = 0;
    bit          calm = 1'b0;

    pan_coordinator_frame_responder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .reply_valid (reply_valid),
        .reply_stall (reply_stall),
        .reply       (reply),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------- prediction

    function automatic void set_online(logic hit_a, logic hit_b, logic v);
        if (hit_a)
            dev_online[0] = v;
        if (hit_b)
            dev_online[1] = v;
    endfunction

    function automatic void load_seq(logic hit_a, logic hit_b, logic [7:0] v);
        if (hit_a)
            dev_seq[0] = v;
        if (hit_b)
            dev_seq[1] = v;
    endfunction

    // Read with post-increment; device B wins when both match
    function automatic logic [7:0] take_seq(logic hit_a, logic hit_b);
        logic [7:0] r;
        r = 8'h00;
        if (hit_a)
        begin
            r = dev_seq[0];
            dev_seq[0] = dev_seq[0] + 8'd1;
        end
        if (hit_b)
        begin
            r = dev_seq[1];
            dev_seq[1] = dev_seq[1] + 8'd1;
        end
        return r;
    endfunction

    function automatic logic [7:0] next_tx();
        logic [7:0] t;
        t = tx_seq;
        tx_seq = tx_seq + 8'd1;
        return t;
    endfunction

    function automatic out_item_t predict_reply(in_item_t f);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] d [7];
        logic       hit_a;
        logic       hit_b;
        logic       online;
        out_item_t  r;
        r = '0;
        for (int j = 0; j < 7; j++)
            d[j] = 8'h00;
        hit_a  = (f.src_address == dev_addr[0]);
        hit_b  = (f.src_address == dev_addr[1]);
        b0     = (f.payload_len > 7'd0) ? f.byte_first  : 8'h00;
        b1     = (f.payload_len > 7'd1) ? f.byte_second : 8'h00;
        b2     = (f.payload_len > 7'd2) ? f.byte_third  : 8'h00;
        online = hit_b ? dev_online[1] : (hit_a ? dev_online[0] : 1'b0);

        if (f.payload_len == 7'd0)
            r.forward_up = 1'b1;
        else if (b0 == KIND_BEACON)
        begin
            set_online(hit_a, hit_b, 1'b0);
            r.send_reply       = 1'b1;
            r.dest_addr_mode   = DAM_NONE;
            r.reply_frame_type = FT_BEACON;
            r.reply_len        = 3'd7;
            d[0] = RB_BEACON_HDR;
            d[1] = RB_BEACON_ID;
            d[4] = RB_BEACON_MARK;
            d[5] = (b1 == DEVTYPE_ONE) ? BEACON_SLOT_ONE : BEACON_SLOT_TWO;
        end
        else if (!online && b0 == KIND_ASSOC_DATA)
        begin
            set_online(hit_a, hit_b, 1'b0);
            r.send_reply       = 1'b1;
            r.dest_addr_mode   = DAM_LONG;
            r.reply_frame_type = FT_COMMAND;
            r.pan_compress     = 1'b1;
            r.ack_request      = 1'b1;
            r.reply_len        = 3'd4;
            d[0] = RB_ASSOC_CMD;
            d[1] = RB_ASSOC_FE;
            d[2] = RB_ASSOC_FF;
        end
        else if (b0 == KIND_START)
        begin
            set_online(hit_a, hit_b, 1'b1);
            load_seq(hit_a, hit_b, b1);
            r.send_reply       = 1'b1;
            r.dest_addr_mode   = DAM_LONG;
            r.reply_frame_type = FT_DATA;
            r.pan_compress     = 1'b1;
            r.ack_request      = 1'b1;
            r.reply_len        = 3'd4;
            d[0] = RB_START_ACK;
            d[1] = next_tx();
            d[2] = b1;
        end
        else if (b0 == KIND_ONLINE)
        begin
            set_online(hit_a, hit_b, 1'b1);
            r.send_reply       = 1'b1;
            r.dest_addr_mode   = DAM_LONG;
            r.reply_frame_type = FT_DATA;
            r.pan_compress     = 1'b1;
            r.reply_len        = 3'd3;
            d[0] = (b2 == MORE_FLAG) ? RB_MORE : RB_DONE;
            d[1] = next_tx();
            d[2] = take_seq(hit_a, hit_b);
        end
        else if (online && b0 == KIND_ASSOC_DATA)
        begin
            set_online(hit_a, hit_b, 1'b1);
            load_seq(hit_a, hit_b, b1);
            r.send_reply       = 1'b1;
            r.dest_addr_mode   = DAM_LONG;
            r.reply_frame_type = FT_DATA;
            r.pan_compress     = 1'b1;
            r.reply_len        = 3'd4;
            r.forward_up       = 1'b1;
            d[0] = (b2 == MORE_FLAG) ? RB_MORE : RB_DATA_DONE;
            d[1] = next_tx();
            d[2] = b1;
        end
        else if (b0 == KIND_FINAL_ACK)
        begin
            set_online(hit_a, hit_b, 1'b1);
            r.send_reply       = 1'b1;
            r.dest_addr_mode   = DAM_LONG;
            r.reply_frame_type = FT_DATA;
            r.pan_compress     = 1'b1;
            r.reply_len        = 3'd4;
            r.forward_up       = 1'b1;
            d[0] = (b2 == MORE_FLAG) ? RB_MORE : RB_DONE;
            d[1] = next_tx();
            d[2] = take_seq(hit_a, hit_b);
        end
        else if (b0 == KIND_RESYNC)
            load_seq(hit_a, hit_b, b1);
        else
            r.forward_up = 1'b1;

        for (int j = 0; j < 7; j++)
            if (j < r.reply_len)
                r.reply_bytes[8*j +: 8] = d[j];
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic in_item_t make_frame(logic [63:0] addr, logic [6:0] len,
                                            logic [7:0] b0, logic [7:0] b1,
                                            logic [7:0] b2);
        in_item_t f;
        f.src_address = addr;
        f.payload_len = len;
        f.byte_first  = b0;
        f.byte_second = b1;
        f.byte_third  = b2;
        return f;
    endfunction

    function automatic logic [63:0] random_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t random_frame();
        in_item_t f;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            f.src_address = dev_addr[0];
        else if (pick < 80)
            f.src_address = dev_addr[1];
        else if (pick < 92)
            f.src_address = random_addr();
        else
            f.src_address = $urandom_range(0, 1) ? ADDR_ALL_ONES : 64'h0;

        if ($urandom_range(0, 99) < 85)
            f.payload_len = 7'($urandom_range(3, 127));
        else
            f.payload_len = 7'($urandom_range(0, 2));

        if ($urandom_range(0, 99) < 85)
            case ($urandom_range(0, 9))
                0:       f.byte_first = KIND_BEACON;
                1, 2, 3: f.byte_first = KIND_ASSOC_DATA;
                4:       f.byte_first = KIND_START;
                5, 6:    f.byte_first = KIND_ONLINE;
                7, 8:    f.byte_first = KIND_FINAL_ACK;
                default: f.byte_first = KIND_RESYNC;
            endcase
        else
            f.byte_first = 8'($urandom_range(0, 255));

        pick = $urandom_range(0, 9);
        f.byte_second = (pick == 0) ? DEVTYPE_ONE :
                        (pick == 1) ? DEVTYPE_TWO : 8'($urandom_range(0, 255));
        f.byte_third  = $urandom_range(0, 1) ? MORE_FLAG : 8'($urandom_range(0, 255));
        return f;
    endfunction

    // Present one request, hold it until accepted, then predict its reply
    task automatic send_frame(in_item_t f);
        int unsigned gap;
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 11);
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame       <= f;
        frame_valid <= 1'b1;
        do
            @(posedge clk);
        while (frame_stall);
        expected_replies.push_back(predict_reply(f));
    endtask

    task automatic wait_replies_done();
        frame_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_address(logic idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        dev_addr[idx] = value;
        @(posedge clk);
    endtask

    task automatic set_addresses(logic [63:0] a, logic [63:0] b);
        wait_replies_done();
        write_address(REG_DEVICE_ADDRESS_A, a);
        write_address(REG_DEVICE_ADDRESS_B, b);
    endtask

    // ---------------------------------------------------------------- tests

    // Both addresses are zero out of reset, so address zero hits both devices
    task automatic test_after_reset();
        logic [63:0] other;
        other = random_addr() | 64'h1;
        idle_pct = 20;
        send_frame(make_frame(64'h0, 7'd3, KIND_START, 8'h55, 8'h00));
        send_frame(make_frame(64'h0, 7'd3, KIND_ONLINE, 8'h00, MORE_FLAG));
        send_frame(make_frame(64'h0, 7'd3, KIND_FINAL_ACK, 8'h00, 8'h00));
        send_frame(make_frame(other, 7'd3, KIND_ASSOC_DATA, 8'h12, 8'h00));
    endtask

    task automatic test_each_case();
        logic [63:0] a;
        logic [63:0] b;
        a = random_addr();
        b = ~a;
        set_addresses(a, b);
        idle_pct = 30;
        send_frame(make_frame(a, 7'd3, KIND_BEACON, DEVTYPE_ONE, 8'h00));
        send_frame(make_frame(b, 7'd3, KIND_BEACON, DEVTYPE_TWO, 8'h00));
        send_frame(make_frame(a, 7'd2, KIND_BEACON, 8'h33, 8'hFF));
        send_frame(make_frame(a, 7'd3, KIND_ASSOC_DATA, 8'h44, 8'h00));
        send_frame(make_frame(a, 7'd3, KIND_START, 8'hFE, 8'h00));
        send_frame(make_frame(a, 7'd3, KIND_ONLINE, 8'h00, MORE_FLAG));
        send_frame(make_frame(a, 7'd3, KIND_ONLINE, 8'h00, 8'h00));
        send_frame(make_frame(a, 7'd3, KIND_ASSOC_DATA, 8'h80, MORE_FLAG));
        send_frame(make_frame(a, 7'd127, KIND_ASSOC_DATA, 8'h81, 8'hFE));
        send_frame(make_frame(a, 7'd3, KIND_FINAL_ACK, 8'h00, MORE_FLAG));
        send_frame(make_frame(b, 7'd3, KIND_FINAL_ACK, 8'h00, 8'h00));
        send_frame(make_frame(b, 7'd3, KIND_RESYNC, 8'hC3, 8'h00));
        send_frame(make_frame(b, 7'd3, KIND_FINAL_ACK, 8'hFF, 8'hFF));
        send_frame(make_frame(a, 7'd127, KIND_UNKNOWN, 8'hFF, 8'hFF));
        // empty payload counts as unknown whatever the bytes say
        send_frame(make_frame(a, 7'd0, KIND_START, 8'h77, MORE_FLAG));
        // missing bytes read as zero
        send_frame(make_frame(b, 7'd1, KIND_START, 8'hAA, 8'hBB));
        send_frame(make_frame(b, 7'd2, KIND_ONLINE, 8'h10, MORE_FLAG));
        send_frame(make_frame(b, 7'd1, KIND_RESYNC, 8'h99, 8'h00));
        // unmatched addresses leave device state alone
        send_frame(make_frame(ADDR_ALL_ONES ^ 64'h1, 7'd3, KIND_START, 8'h5A, 8'h00));
        send_frame(make_frame(64'h0, 7'd3, KIND_ONLINE, 8'h00, 8'h00));
        send_frame(make_frame(a ^ 64'h8000_0000_0000_0000, 7'd3, KIND_ASSOC_DATA,
                              8'h01, 8'h00));
        send_frame(make_frame(a, 7'd3, KIND_BEACON, 8'h00, 8'h00));
        send_frame(make_frame(a, 7'd3, KIND_ASSOC_DATA, 8'h00, 8'h00));
    endtask

    // Same address in both registers: writes hit both, reads take device B
    task automatic test_shared_address();
        logic [63:0] s;
        s = random_addr();
        set_addresses(s, s);
        idle_pct = 20;
        send_frame(make_frame(s, 7'd3, KIND_START, 8'h20, 8'h00));
        send_frame(make_frame(s, 7'd3, KIND_ONLINE, 8'h00, 8'h00));
        send_frame(make_frame(s, 7'd3, KIND_RESYNC, 8'h7F, 8'h00));
        send_frame(make_frame(s, 7'd3, KIND_FINAL_ACK, 8'h00, MORE_FLAG));
        send_frame(make_frame(s, 7'd3, KIND_ASSOC_DATA, 8'h31, 8'h00));
        send_frame(make_frame(s, 7'd3, KIND_BEACON, 8'h00, 8'h00));
        send_frame(make_frame(s, 7'd3, KIND_ASSOC_DATA, 8'h31, 8'h00));
    endtask

    task automatic test_random_traffic(logic [63:0] a, logic [63:0] b,
                                       int unsigned count, int unsigned pct,
                                       bit no_idle);
        set_addresses(a, b);
        idle_pct = pct;
        calm     = no_idle;
        repeat (count)
            send_frame(random_frame());
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            failures++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && reply_valid && !reply_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("reply with none outstanding: %h", reply);
            end
            else
            begin
                want = expected_replies.pop_front();
                check_field("send_reply", 64'(want.send_reply), 64'(reply.send_reply));
                check_field("dest_addr_mode", 64'(want.dest_addr_mode),
                            64'(reply.dest_addr_mode));
                check_field("reply_frame_type", 64'(want.reply_frame_type),
                            64'(reply.reply_frame_type));
                check_field("pan_compress", 64'(want.pan_compress),
                            64'(reply.pan_compress));
                check_field("ack_request", 64'(want.ack_request),
                            64'(reply.ack_request));
                check_field("reply_len", 64'(want.reply_len), 64'(reply.reply_len));
                check_field("reply_bytes", 64'(want.reply_bytes),
                            64'(reply.reply_bytes));
                check_field("forward_up", 64'(want.forward_up), 64'(reply.forward_up));
            end
        end
    end

    // Hold off the reply side in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            reply_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 99) < idle_pct / 3)
        begin
            reply_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 10);
        end
        else
            reply_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((frame_valid && !frame_stall) || (reply_valid && !reply_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        dev_addr[0]   = '0;
        dev_addr[1]   = '0;
        dev_online[0] = 1'b0;
        dev_online[1] = 1'b0;
        dev_seq[0]    = '0;
        dev_seq[1]    = '0;
        tx_seq        = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_each_case();
        test_shared_address();
        test_random_traffic(random_addr(), random_addr(), 500, 30, 1'b0);
        test_random_traffic(64'h0, ADDR_ALL_ONES, 400, 60, 1'b0);
        test_random_traffic(ADDR_ALL_ONES, ADDR_ALL_ONES, 350, 20, 1'b0);
        test_random_traffic(ADDR_ALL_ONES, 64'h0, 300, 10, 1'b0);
        test_random_traffic(random_addr(), random_addr(), 400, 0, 1'b1);

        wait_replies_done();
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> pan_coordinator_frame_responder_top.f
+incdir+src
src/pcfr_pkg.sv
src/pcfr_decode.sv
src/pan_coordinator_frame_responder_top.sv
src/pcfr_checker.sv
sim/pan_coordinator_frame_responder_top_tb.sv
